// ===== sv/hsvrgb_pkg.sv =====
// Shared constants, sector codes and stage payload types of the HSV to RGB565 converter.
package hsvrgb_pkg;

   // Percent inputs are limited to full scale before rescaling
   localparam logic [6:0]  PCT_FULL    = 7'd100;
   // x * 255 / 100 == (x * 255 * 5243) >> 19 for x in 0..100
   localparam logic [26:0] PCT_RECIP   = 27'd1336965;
   // hue * 255 / 360 == ((hue * 17) >> 3) / 3
   localparam logic [4:0]  HUE_MUL     = 5'd17;
   // y / 3 == (y * 43691) >> 17 for y up to 1085
   localparam logic [15:0] THIRD_RECIP = 16'd43691;
   // h / 43 == (h * 191) >> 13 for h up to 361
   localparam logic [7:0]  SECTOR_RECIP = 8'd191;
   localparam logic [5:0]  SECTOR_SPAN  = 6'd43;
   localparam logic [2:0]  REM_SCALE    = 3'd6;
   localparam logic [7:0]  CH_MAX       = 8'hFF;

   // Hue sectors; everything from five up shares the last sector
   localparam logic [3:0]  SEC_RED    = 4'd0;
   localparam logic [3:0]  SEC_YELLOW = 4'd1;
   localparam logic [3:0]  SEC_GREEN  = 4'd2;
   localparam logic [3:0]  SEC_CYAN   = 4'd3;
   localparam logic [3:0]  SEC_BLUE   = 4'd4;

   typedef struct packed {
      logic [8:0] hue_deg;   // hue rescaled to 0..361
      logic [7:0] sat;       // saturation rescaled to 0..255
      logic [7:0] val;       // value rescaled to 0..255
      logic       grey;      // zero saturation
   } scaled_type;

   typedef struct packed {
      logic [3:0] region;
      logic [7:0] rem;
      logic [7:0] sat;
      logic [7:0] val;
      logic       grey;
   } sector_type;

endpackage

// ===== sv/hsvrgb_scale.sv =====
// Two pipeline stages that limit and rescale hue, saturation and value.
module hsvrgb_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [8:0]             in_hue,
   input  logic [6:0]             in_sat,
   input  logic [6:0]             in_val,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hsvrgb_pkg::scaled_type out_pix
);
   import hsvrgb_pkg::*;

   logic        s1_valid_ff;
   logic [10:0] s1_third_ff;
   logic [10:0] s1_third_in;
   logic [7:0]  s1_sat_ff;
   logic [7:0]  s1_sat_in;
   logic [7:0]  s1_val_ff;
   logic [7:0]  s1_val_in;
   logic        s1_grey_ff;
   logic        s1_grey_in;
   logic        s2_valid_ff;
   scaled_type  s2_pix_ff;
   scaled_type  s2_pix_in;
   logic        s1_ready;
   logic        s2_ready;
   logic [6:0]  sat_lim;
   logic [6:0]  val_lim;
   logic [13:0] hue_x17;
   logic [26:0] sat_prod;
   logic [26:0] val_prod;
   logic [26:0] third_prod;

   // Stage advances when empty or when the next one takes its transaction
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_ready  = s1_ready;
   assign out_valid = s2_valid_ff;
   assign out_pix   = s2_pix_ff;

   // Stage 1: limit percents, rescale them, pre-scale hue by 17/8
   always_comb begin
      sat_lim     = (in_sat > PCT_FULL) ? PCT_FULL : in_sat;
      val_lim     = (in_val > PCT_FULL) ? PCT_FULL : in_val;
      sat_prod    = 27'(sat_lim) * PCT_RECIP;
      val_prod    = 27'(val_lim) * PCT_RECIP;
      hue_x17     = 14'(in_hue) * 14'(HUE_MUL);
      s1_third_in = hue_x17[13:3];
      s1_sat_in   = sat_prod[26:19];
      s1_val_in   = val_prod[26:19];
      s1_grey_in  = (in_sat == 7'd0);
   end

   // Stage 2: finish hue rescale with a divide by three
   always_comb begin
      third_prod        = 27'(s1_third_ff) * 27'(THIRD_RECIP);
      s2_pix_in.hue_deg = third_prod[25:17];
      s2_pix_in.sat     = s1_sat_ff;
      s2_pix_in.val     = s1_val_ff;
      s2_pix_in.grey    = s1_grey_ff;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Load payload only with a live transaction
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_third_ff <= s1_third_in;
         s1_sat_ff   <= s1_sat_in;
         s1_val_ff   <= s1_val_in;
         s1_grey_ff  <= s1_grey_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_pix_ff <= s2_pix_in;
      end
   end

endmodule

// ===== sv/hsvrgb_sector.sv =====
// Two pipeline stages that split the scaled hue into sector and scaled remainder.
module hsvrgb_sector (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hsvrgb_pkg::scaled_type in_pix,
   output logic                   out_valid,
   input  logic                   out_ready,
   output hsvrgb_pkg::sector_type out_sec
);
   import hsvrgb_pkg::*;

   logic        s3_valid_ff;
   scaled_type  s3_pix_ff;
   logic [3:0]  s3_region_ff;
   logic [3:0]  s3_region_in;
   logic        s4_valid_ff;
   sector_type  s4_sec_ff;
   sector_type  s4_sec_in;
   logic        s3_ready;
   logic        s4_ready;
   logic [16:0] region_prod;
   logic [8:0]  span;
   logic [8:0]  diff;
   logic [8:0]  rem_full;

   assign s4_ready  = !s4_valid_ff || out_ready;
   assign s3_ready  = !s3_valid_ff || s4_ready;
   assign in_ready  = s3_ready;
   assign out_valid = s4_valid_ff;
   assign out_sec   = s4_sec_ff;

   // Stage 3: sector index as hue / 43
   always_comb begin
      region_prod  = 17'(in_pix.hue_deg) * 17'(SECTOR_RECIP);
      s3_region_in = region_prod[16:13];
   end

   // Stage 4: remainder within the sector, times six
   always_comb begin
      span             = 9'(s3_region_ff) * 9'(SECTOR_SPAN);
      diff             = s3_pix_ff.hue_deg - span;
      rem_full         = diff * 9'(REM_SCALE);
      s4_sec_in.region = s3_region_ff;
      s4_sec_in.rem    = rem_full[7:0];
      s4_sec_in.sat    = s3_pix_ff.sat;
      s4_sec_in.val    = s3_pix_ff.val;
      s4_sec_in.grey   = s3_pix_ff.grey;
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s3_ready) begin
            s3_valid_ff <= in_valid;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Load payload
   always_ff @(posedge clock) begin
      if (s3_ready && in_valid) begin
         s3_pix_ff    <= in_pix;
         s3_region_ff <= s3_region_in;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_sec_ff <= s4_sec_in;
      end
   end

   // Sector index must bracket the scaled hue
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (span <= s3_pix_ff.hue_deg) && (diff < 9'(SECTOR_SPAN)))
      else $error("sector index does not bracket scaled hue");

   assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> (s4_sec_ff.region <= 4'd8) && (s4_sec_ff.rem <= 8'd252))
      else $error("sector or remainder out of range");

endmodule

// ===== sv/hsvrgb_mix.sv =====
// Three pipeline stages that form p, q and t, pick the RGB triple and pack RGB565.
module hsvrgb_mix (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  hsvrgb_pkg::sector_type in_sec,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_red,
   output logic [7:0]             out_green,
   output logic [7:0]             out_blue,
   output logic [15:0]            out_packed
);
   import hsvrgb_pkg::*;

   logic        s5_valid_ff;
   logic [7:0]  s5_ns_ff;
   logic [7:0]  s5_ns_in;
   logic [7:0]  s5_sq_ff;
   logic [7:0]  s5_sq_in;
   logic [7:0]  s5_st_ff;
   logic [7:0]  s5_st_in;
   logic [7:0]  s5_val_ff;
   logic [3:0]  s5_region_ff;
   logic        s5_grey_ff;
   logic        s6_valid_ff;
   logic [7:0]  s6_p_ff;
   logic [7:0]  s6_p_in;
   logic [7:0]  s6_q_ff;
   logic [7:0]  s6_q_in;
   logic [7:0]  s6_t_ff;
   logic [7:0]  s6_t_in;
   logic [7:0]  s6_val_ff;
   logic [3:0]  s6_region_ff;
   logic        s6_grey_ff;
   logic        s7_valid_ff;
   logic [7:0]  s7_red_ff;
   logic [7:0]  s7_red_in;
   logic [7:0]  s7_green_ff;
   logic [7:0]  s7_green_in;
   logic [7:0]  s7_blue_ff;
   logic [7:0]  s7_blue_in;
   logic [15:0] s7_packed_ff;
   logic [15:0] s7_packed_in;
   logic        s5_ready;
   logic        s6_ready;
   logic        s7_ready;
   logic [15:0] sq_prod;
   logic [15:0] st_prod;
   logic [15:0] p_prod;
   logic [15:0] q_prod;
   logic [15:0] t_prod;

   assign s7_ready   = !s7_valid_ff || out_ready;
   assign s6_ready   = !s6_valid_ff || s7_ready;
   assign s5_ready   = !s5_valid_ff || s6_ready;
   assign in_ready   = s5_ready;
   assign out_valid  = s7_valid_ff;
   assign out_red    = s7_red_ff;
   assign out_green  = s7_green_ff;
   assign out_blue   = s7_blue_ff;
   assign out_packed = s7_packed_ff;

   // Stage 5: saturation-weighted remainders
   always_comb begin
      s5_ns_in = CH_MAX - in_sec.sat;
      sq_prod  = 16'(in_sec.sat) * 16'(in_sec.rem);
      st_prod  = 16'(in_sec.sat) * 16'(CH_MAX - in_sec.rem);
      s5_sq_in = sq_prod[15:8];
      s5_st_in = st_prod[15:8];
   end

   // Stage 6: p, q and t scaled by value
   always_comb begin
      p_prod  = 16'(s5_val_ff) * 16'(s5_ns_ff);
      q_prod  = 16'(s5_val_ff) * 16'(CH_MAX - s5_sq_ff);
      t_prod  = 16'(s5_val_ff) * 16'(CH_MAX - s5_st_ff);
      s6_p_in = p_prod[15:8];
      s6_q_in = q_prod[15:8];
      s6_t_in = t_prod[15:8];
   end

   // Stage 7: pick components by sector and pack
   always_comb begin
      if (s6_grey_ff) begin
         s7_red_in   = s6_val_ff;
         s7_green_in = s6_val_ff;
         s7_blue_in  = s6_val_ff;
      end else begin
         case (s6_region_ff)
            SEC_RED: begin
               s7_red_in = s6_val_ff; s7_green_in = s6_t_ff; s7_blue_in = s6_p_ff;
            end
            SEC_YELLOW: begin
               s7_red_in = s6_q_ff; s7_green_in = s6_val_ff; s7_blue_in = s6_p_ff;
            end
            SEC_GREEN: begin
               s7_red_in = s6_p_ff; s7_green_in = s6_val_ff; s7_blue_in = s6_t_ff;
            end
            SEC_CYAN: begin
               s7_red_in = s6_p_ff; s7_green_in = s6_q_ff; s7_blue_in = s6_val_ff;
            end
            SEC_BLUE: begin
               s7_red_in = s6_t_ff; s7_green_in = s6_p_ff; s7_blue_in = s6_val_ff;
            end
            default: begin
               s7_red_in = s6_val_ff; s7_green_in = s6_p_ff; s7_blue_in = s6_q_ff;
            end
         endcase
      end
      s7_packed_in = {s7_red_in[7:3], s7_green_in[7:2], s7_blue_in[7:3]};
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
      end else begin
         if (s5_ready) begin
            s5_valid_ff <= in_valid;
         end
         if (s6_ready) begin
            s6_valid_ff <= s5_valid_ff;
         end
         if (s7_ready) begin
            s7_valid_ff <= s6_valid_ff;
         end
      end
   end

   // Load payload
   always_ff @(posedge clock) begin
      if (s5_ready && in_valid) begin
         s5_ns_ff     <= s5_ns_in;
         s5_sq_ff     <= s5_sq_in;
         s5_st_ff     <= s5_st_in;
         s5_val_ff    <= in_sec.val;
         s5_region_ff <= in_sec.region;
         s5_grey_ff   <= in_sec.grey;
      end
      if (s6_ready && s5_valid_ff) begin
         s6_p_ff      <= s6_p_in;
         s6_q_ff      <= s6_q_in;
         s6_t_ff      <= s6_t_in;
         s6_val_ff    <= s5_val_ff;
         s6_region_ff <= s5_region_ff;
         s6_grey_ff   <= s5_grey_ff;
      end
      if (s7_ready && s6_valid_ff) begin
         s7_red_ff    <= s7_red_in;
         s7_green_ff  <= s7_green_in;
         s7_blue_ff   <= s7_blue_in;
         s7_packed_ff <= s7_packed_in;
      end
   end

   // Derived components never exceed value
   assert property (@(posedge clock) disable iff (reset)
      s6_valid_ff |-> (s6_p_ff <= s6_val_ff) && (s6_q_ff <= s6_val_ff)
                      && (s6_t_ff <= s6_val_ff))
      else $error("p, q or t exceeds value");

endmodule

// ===== sv/hsv_to_rgb565_converter.sv =====
// Top level of the pipelined HSV to RGB888 / RGB565 pixel converter.
//
// Usage:
//   Request channel (req_valid / req_ready) carries one pixel per transaction:
//   hue in degrees (9 bits), saturation and brightness in percent (7 bits).
//   Saturation and brightness above 100 count as 100; hue past a full turn
//   falls into the last color sector.
//   Response channel (rsp_valid / rsp_ready) returns one transaction per pixel
//   with 8-bit red, green, blue and the packed RGB565 word, in request order.
//
// Pipeline and throughput:
//   Seven register stages: rescale (2), sector split (2), p/q/t forming (2)
//   and the output register. One pixel enters per cycle while the receiver
//   keeps up.
//
// Reset clears all stage valid bits; no result is pending after reset.
// When the receiver holds rsp_ready low, the output register holds its
// transaction and stages fill behind it; req_ready drops only once all
// seven stages hold a pixel.
module hsv_to_rgb565_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [8:0]  req_hue,
   input  logic [6:0]  req_saturation,
   input  logic [6:0]  req_brightness,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [15:0] rsp_packed_565
);
   import hsvrgb_pkg::*;

   logic       scale_valid;
   logic       scale_ready;
   scaled_type scale_pix;
   logic       sector_valid;
   logic       sector_ready;
   sector_type sector_sec;

   // Rescale inputs
   hsvrgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_hue    (req_hue),
      .in_sat    (req_saturation),
      .in_val    (req_brightness),
      .out_valid (scale_valid),
      .out_ready (scale_ready),
      .out_pix   (scale_pix)
   );

   // Split hue into sector and remainder
   hsvrgb_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scale_valid),
      .in_ready  (scale_ready),
      .in_pix    (scale_pix),
      .out_valid (sector_valid),
      .out_ready (sector_ready),
      .out_sec   (sector_sec)
   );

   // Form components and drive the response register
   hsvrgb_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (sector_valid),
      .in_ready   (sector_ready),
      .in_sec     (sector_sec),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_red    (rsp_red),
      .out_green  (rsp_green),
      .out_blue   (rsp_blue),
      .out_packed (rsp_packed_565)
   );

   // Back-pressure reaches the request side only with a full, stalled pipe
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled while response side is free");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_packed_565 == {rsp_red[7:3], rsp_green[7:2], rsp_blue[7:3]})
      else $error("packed word disagrees with components");

endmodule
